[src/qrs_pkg.sv]
// qrs_pkg: widths, kind codes and the queue entry type of the quadratic root solver.
// No dependencies; every other file in src uses these by scoped name.
`default_nettype none
package qrs_pkg;

   localparam int CoefWidth  = 16;                 // coefficient width, Q(n-8).8
   localparam int FracShift  = 16;                 // aligns -b to 24 fraction bits
   localparam int RootShift  = 32;                 // radicand is |D| * 2^32
   localparam int OutWidth   = 32;                 // Q16.16 results
   localparam int DiscWidth  = 2 * CoefWidth + 3;  // signed b*b - 4ac
   localparam int DmagWidth  = DiscWidth - 1;      // |D|
   localparam int RadWidth   = DmagWidth + RootShift;
   localparam int RootWidth  = (RadWidth + 1) / 2;
   localparam int NbWidth    = CoefWidth + FracShift + 1;
   localparam int DenWidth   = CoefWidth + 1;      // 2a, signed; |2a| also fits
   localparam int NumWidth   = ((NbWidth > RootWidth + 1) ? NbWidth : RootWidth + 1) + 1;
   localparam int FifoDepth  = 4;
   localparam int FifoPtrW   = $clog2(FifoDepth);

   typedef enum logic [1:0] {
      KIND_DISTINCT = 2'd0,
      KIND_EQUAL    = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_DEGEN    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic [DmagWidth-1:0]         dmag;
      logic signed [NbWidth-1:0]    nb;
      logic signed [DenWidth-1:0]   den;
   } item_type;

   typedef struct packed {
      logic [FifoPtrW:0] count;
      logic [1:0]        inflight;
   } occ_type;

endpackage
`default_nettype wire

[src/quadratic_root_solver.sv]
// quadratic_root_solver: top level; front classifier, item queue and back-end arithmetic.
// Depends on qrs_pkg, qrs_front, qrs_fifo and qrs_back.
//
//   channel  | handshake        | beat
//   ---------+------------------+-------------------------------------------------
//   request  | start / busy     | req_coef_a, req_coef_b, req_coef_c (Q8.8)
//   response | rsp_strobe       | rsp_root_kind, rsp_first_value,
//            |                  | rsp_second_value (Q16.16), rsp_saturated
//
// One beat per cycle sustained while busy is low; each result passes 2 front stages,
// the queue, 34 square-root stages, 1 prep stage, 36 divider stages and 1 output
// register after its request beat.
// Synchronous active-high reset empties the queue and all valid bits.
// busy guards the queue against overflow; the back end drains it every cycle,
// so busy stays low in steady flow. Results cannot be held off.
`default_nettype none
module quadratic_root_solver (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [qrs_pkg::CoefWidth-1:0]   req_coef_a,
   input  wire logic signed [qrs_pkg::CoefWidth-1:0]   req_coef_b,
   input  wire logic signed [qrs_pkg::CoefWidth-1:0]   req_coef_c,
   output logic                                        rsp_strobe,
   output logic [1:0]                                  rsp_root_kind,
   output logic signed [qrs_pkg::OutWidth-1:0]         rsp_first_value,
   output logic signed [qrs_pkg::OutWidth-1:0]         rsp_second_value,
   output logic                                        rsp_saturated
);

   logic                 accept;
   logic                 push, pop;
   qrs_pkg::item_type    push_item, pop_item;
   qrs_pkg::occ_type     occ;

   assign accept = start && !busy;
   assign busy   = ({1'b0, occ.count} + (qrs_pkg::FifoPtrW+2)'(occ.inflight))
                   >= (qrs_pkg::FifoPtrW+2)'(qrs_pkg::FifoDepth);

   qrs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .coef_a   (req_coef_a),
      .coef_b   (req_coef_b),
      .coef_c   (req_coef_c),
      .push     (push),
      .item     (push_item),
      .inflight (occ.inflight)
   );

   qrs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .count     (occ.count)
   );

   qrs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (pop),
      .in_item          (pop_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_root_kind    (rsp_root_kind),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_saturated    (rsp_saturated)
   );

endmodule
`default_nettype wire

[src/qrs_front.sv]
// qrs_front: takes coefficient beats, forms b*b and a*c, then the discriminant and kind.
// Depends on qrs_pkg.
`default_nettype none
module qrs_front (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      accept,
   input  wire logic signed [qrs_pkg::CoefWidth-1:0]      coef_a,
   input  wire logic signed [qrs_pkg::CoefWidth-1:0]      coef_b,
   input  wire logic signed [qrs_pkg::CoefWidth-1:0]      coef_c,
   output logic                                           push,
   output qrs_pkg::item_type                              item,
   output logic [1:0]                                     inflight
);

   logic                                        v1_ff, v2_ff;
   logic signed [qrs_pkg::CoefWidth-1:0]        a1_ff, b1_ff;
   logic signed [2*qrs_pkg::CoefWidth-1:0]      bb_ff, ac_ff, bb_in, ac_in;
   logic signed [qrs_pkg::DiscWidth-1:0]        disc;
   qrs_pkg::item_type                           item_ff, item_in;

   assign bb_in = coef_b * coef_b;
   assign ac_in = coef_a * coef_c;
   assign disc  = qrs_pkg::DiscWidth'(bb_ff) - (qrs_pkg::DiscWidth'(ac_ff) <<< 2);

   always_comb begin
      item_in.nb  = -(qrs_pkg::NbWidth'(b1_ff) <<< qrs_pkg::FracShift);
      item_in.den = qrs_pkg::DenWidth'(a1_ff) <<< 1;
      item_in.dmag = disc[qrs_pkg::DiscWidth-1] ? qrs_pkg::DmagWidth'(-disc)
                                                : qrs_pkg::DmagWidth'(disc);
      if (a1_ff == '0) begin
         item_in.kind = qrs_pkg::KIND_DEGEN;
      end else if (disc == '0) begin
         item_in.kind = qrs_pkg::KIND_EQUAL;
      end else if (disc[qrs_pkg::DiscWidth-1]) begin
         item_in.kind = qrs_pkg::KIND_COMPLEX;
      end else begin
         item_in.kind = qrs_pkg::KIND_DISTINCT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
      a1_ff   <= coef_a;
      b1_ff   <= coef_b;
      bb_ff   <= bb_in;
      ac_ff   <= ac_in;
      item_ff <= item_in;
   end

   assign push     = v2_ff;
   assign item     = item_ff;
   assign inflight = {1'b0, v1_ff} + {1'b0, v2_ff};

endmodule
`default_nettype wire

[src/qrs_fifo.sv]
// qrs_fifo: short queue of classified items between front and back.
// Depends on qrs_pkg.
`default_nettype none
module qrs_fifo (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire qrs_pkg::item_type          push_item,
   output logic                            pop,
   output qrs_pkg::item_type               pop_item,
   output logic [qrs_pkg::FifoPtrW:0]      count
);

   qrs_pkg::item_type                 mem_ff [qrs_pkg::FifoDepth];
   logic [qrs_pkg::FifoPtrW-1:0]      wr_ff, rd_ff;
   logic [qrs_pkg::FifoPtrW:0]        cnt_ff;

   // back end never stalls: drain whenever something is queued
   assign pop      = (cnt_ff != '0);
   assign pop_item = mem_ff[rd_ff];
   assign count    = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + {{qrs_pkg::FifoPtrW{1'b0}}, push}
                          - {{qrs_pkg::FifoPtrW{1'b0}}, pop};
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

endmodule
`default_nettype wire

[src/qrs_sqrt.sv]
// qrs_sqrt: pipelined integer square root of |D| * 2^32, one root bit per stage.
// Depends on qrs_pkg; carries the queue entry alongside.
`default_nettype none
module qrs_sqrt (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire qrs_pkg::item_type                 in_item,
   output logic                                   out_valid,
   output qrs_pkg::item_type                      out_item,
   output logic [qrs_pkg::RootWidth-1:0]          out_root
);

   localparam int SW   = qrs_pkg::RootWidth;
   localparam int RemW = SW + 2;
   localparam int PadW = 2 * SW;

   logic                  vld_ff  [SW+1];
   qrs_pkg::item_type     item_ff [SW+1];
   logic [PadW-1:0]       rad_ff  [SW+1];
   logic [RemW-1:0]       rem_ff  [SW+1];
   logic [SW-1:0]         root_ff [SW+1];

   logic [RemW-1:0]       rem_sh  [SW];
   logic [RemW-1:0]       trial   [SW];
   logic                  ge      [SW];
   logic [RemW-1:0]       rem_in  [SW];
   logic [SW-1:0]         root_in [SW];

   always_comb begin
      for (int k = 0; k < SW; k++) begin
         rem_sh[k]  = {rem_ff[k][RemW-3:0], rad_ff[k][PadW-1 -: 2]};
         trial[k]   = {root_ff[k], 2'b01};
         ge[k]      = (rem_sh[k] >= trial[k]);
         rem_in[k]  = ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
         root_in[k] = {root_ff[k][SW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SW; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 0; k < SW; k++) vld_ff[k+1] <= vld_ff[k];
      end
      item_ff[0] <= in_item;
      rad_ff[0]  <= PadW'({in_item.dmag, {qrs_pkg::RootShift{1'b0}}});
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      for (int k = 0; k < SW; k++) begin
         item_ff[k+1] <= item_ff[k];
         rad_ff[k+1]  <= rad_ff[k] << 2;
         rem_ff[k+1]  <= rem_in[k];
         root_ff[k+1] <= root_in[k];
      end
   end

   assign out_valid = vld_ff[SW];
   assign out_item  = item_ff[SW];
   assign out_root  = root_ff[SW];

endmodule
`default_nettype wire

[src/qrs_div.sv]
// qrs_div: pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on qrs_pkg for the numerator and divisor widths.
`default_nettype none
module qrs_div (
   input  wire logic                              clock,
   input  wire logic [qrs_pkg::NumWidth-1:0]      num,
   input  wire logic [qrs_pkg::DenWidth-1:0]      den,
   output logic [qrs_pkg::NumWidth-1:0]           quot
);

   localparam int NW = qrs_pkg::NumWidth;
   localparam int DW = qrs_pkg::DenWidth;

   logic [NW-1:0]  num_ff [NW+1];
   logic [DW-1:0]  den_ff [NW+1];
   logic [DW-1:0]  rem_ff [NW+1];
   logic [DW:0]    sh     [NW];
   logic           ge     [NW];
   logic [DW:0]    diff   [NW];

   always_comb begin
      for (int k = 0; k < NW; k++) begin
         sh[k]   = {rem_ff[k], num_ff[k][NW-1]};
         ge[k]   = (sh[k] >= {1'b0, den_ff[k]});
         diff[k] = sh[k] - {1'b0, den_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= num;
      den_ff[0] <= den;
      rem_ff[0] <= '0;
      for (int k = 0; k < NW; k++) begin
         num_ff[k+1] <= {num_ff[k][NW-2:0], ge[k]};
         den_ff[k+1] <= den_ff[k];
         rem_ff[k+1] <= ge[k] ? diff[k][DW-1:0] : sh[k][DW-1:0];
      end
   end

   assign quot = num_ff[NW];

endmodule
`default_nettype wire

[src/qrs_back.sv]
// qrs_back: square root, numerator prep, two dividers, sign, clip and result register.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
`default_nettype none
module qrs_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire qrs_pkg::item_type                  in_item,
   output logic                                    rsp_strobe,
   output logic [1:0]                              rsp_root_kind,
   output logic signed [qrs_pkg::OutWidth-1:0]     rsp_first_value,
   output logic signed [qrs_pkg::OutWidth-1:0]     rsp_second_value,
   output logic                                    rsp_saturated
);

   localparam int NW = qrs_pkg::NumWidth;
   localparam int QW = NW + 1;
   localparam int OW = qrs_pkg::OutWidth;

   logic                              sq_valid;
   qrs_pkg::item_type                 sq_item;
   logic [qrs_pkg::RootWidth-1:0]     sq_root;

   logic signed [NW-1:0]              nbx, sx, n1, n2;
   logic                              pv_ff;
   qrs_pkg::kind_type                 pk_ff;
   logic [NW-1:0]                     m1_ff, m2_ff;
   logic                              g1_ff, g2_ff;
   logic [qrs_pkg::DenWidth-1:0]      dm_ff;

   logic                              lv_ff [NW+1];
   qrs_pkg::kind_type                 lk_ff [NW+1];
   logic                              l1_ff [NW+1];
   logic                              l2_ff [NW+1];
   logic [NW-1:0]                     q1, q2;
   logic signed [QW-1:0]              s1, s2;
   logic                              hi1, lo1, hi2, lo2;
   logic signed [OW-1:0]              o1, o2;

   logic                              strobe_ff;
   logic [1:0]                        kind_ff;
   logic signed [OW-1:0]              first_ff, second_ff;
   logic                              sat_ff;

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .out_valid (sq_valid),
      .out_item  (sq_item),
      .out_root  (sq_root)
   );

   // equal roots give a zero root, so x1 = x2 = -b/2a falls out of nb +/- s
   always_comb begin
      nbx = NW'(sq_item.nb);
      sx  = NW'({1'b0, sq_root});
      n1  = (sq_item.kind == qrs_pkg::KIND_COMPLEX) ? nbx : nbx + sx;
      n2  = (sq_item.kind == qrs_pkg::KIND_COMPLEX) ? sx  : nbx - sx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= sq_valid;
      end
      pk_ff <= sq_item.kind;
      m1_ff <= n1[NW-1] ? NW'(-n1) : NW'(n1);
      m2_ff <= n2[NW-1] ? NW'(-n2) : NW'(n2);
      g1_ff <= n1[NW-1] ^ sq_item.den[qrs_pkg::DenWidth-1];
      g2_ff <= n2[NW-1] ^ sq_item.den[qrs_pkg::DenWidth-1];
      dm_ff <= sq_item.den[qrs_pkg::DenWidth-1] ? qrs_pkg::DenWidth'(-sq_item.den)
                                                : qrs_pkg::DenWidth'(sq_item.den);
   end

   qrs_div u_div1 (.clock(clock), .num(m1_ff), .den(dm_ff), .quot(q1));
   qrs_div u_div2 (.clock(clock), .num(m2_ff), .den(dm_ff), .quot(q2));

   // kind and signs ride alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NW; k++) lv_ff[k] <= 1'b0;
      end else begin
         lv_ff[0] <= pv_ff;
         for (int k = 0; k < NW; k++) lv_ff[k+1] <= lv_ff[k];
      end
      lk_ff[0] <= pk_ff;
      l1_ff[0] <= g1_ff;
      l2_ff[0] <= g2_ff;
      for (int k = 0; k < NW; k++) begin
         lk_ff[k+1] <= lk_ff[k];
         l1_ff[k+1] <= l1_ff[k];
         l2_ff[k+1] <= l2_ff[k];
      end
   end

   always_comb begin
      s1  = l1_ff[NW] ? -QW'(q1) : QW'(q1);
      s2  = l2_ff[NW] ? -QW'(q2) : QW'(q2);
      hi1 = !s1[QW-1] &&  (|s1[QW-2:OW-1]);
      lo1 =  s1[QW-1] && !(&s1[QW-2:OW-1]);
      hi2 = !s2[QW-1] &&  (|s2[QW-2:OW-1]);
      lo2 =  s2[QW-1] && !(&s2[QW-2:OW-1]);
      o1  = hi1 ? {1'b0, {(OW-1){1'b1}}} : lo1 ? {1'b1, {(OW-1){1'b0}}} : s1[OW-1:0];
      o2  = hi2 ? {1'b0, {(OW-1){1'b1}}} : lo2 ? {1'b1, {(OW-1){1'b0}}} : s2[OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= lv_ff[NW];
      end
      kind_ff <= lk_ff[NW];
      if (lk_ff[NW] == qrs_pkg::KIND_DEGEN) begin
         first_ff  <= '0;
         second_ff <= '0;
         sat_ff    <= 1'b0;
      end else begin
         first_ff  <= o1;
         second_ff <= o2;
         sat_ff    <= hi1 | lo1 | hi2 | lo2;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_root_kind    = kind_ff;
   assign rsp_first_value  = first_ff;
   assign rsp_second_value = second_ff;
   assign rsp_saturated    = sat_ff;

endmodule
`default_nettype wire

[tb/sv/quadratic_root_solver_chk.sv]
// quadratic_root_solver_chk: watches request and response beats, predicts roots, compares.
// Depends on qrs_pkg for widths and kind codes.
module quadratic_root_solver_chk (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 busy,
   input  wire logic signed [qrs_pkg::CoefWidth-1:0] req_coef_a,
   input  wire logic signed [qrs_pkg::CoefWidth-1:0] req_coef_b,
   input  wire logic signed [qrs_pkg::CoefWidth-1:0] req_coef_c,
   input  wire logic                                 rsp_strobe,
   input  wire logic [1:0]                           rsp_root_kind,
   input  wire logic signed [qrs_pkg::OutWidth-1:0]  rsp_first_value,
   input  wire logic signed [qrs_pkg::OutWidth-1:0]  rsp_second_value,
   input  wire logic                                 rsp_saturated,
   output int                                        fail_count,
   output int                                        pending_roots
);

   typedef struct {
      qrs_pkg::kind_type kind;
      logic [31:0]       x1;
      logic [31:0]       x2;
      logic              sat;
   } roots_type;

   roots_type root_queue[$];

   function automatic logic [63:0] int_sqrt(logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  t;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if ({64'd0, t} * {64'd0, t} <= n) r = t;
      end
      return r;
   endfunction

   function automatic logic [31:0] clip32(longint q, inout logic sat);
      if (q > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'h7fffffff;
      end
      if (q < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return q[31:0];
   endfunction

   function automatic roots_type solve_roots(longint a, longint b, longint c);
      roots_type r;
      longint  disc;
      longint  den;
      longint  nb;
      longint  s;
      longint  v1;
      longint  v2;
      r.sat = 1'b0;
      if (a == 0) begin
         r.kind = qrs_pkg::KIND_DEGEN;
         r.x1 = 0;
         r.x2 = 0;
         return r;
      end
      // fits in 64 bits for 16-bit coefficients
      disc = b * b - 4 * a * c;
      if (disc > 0) r.kind = qrs_pkg::KIND_DISTINCT;
      else if (disc == 0) r.kind = qrs_pkg::KIND_EQUAL;
      else r.kind = qrs_pkg::KIND_COMPLEX;
      den = 2 * a;
      nb = -(b * 65536);
      if (disc < 0) disc = -disc;
      s = longint'(int_sqrt({64'd0, disc} << 32));
      case (r.kind)
         qrs_pkg::KIND_EQUAL: begin
            v1 = nb / den;
            v2 = v1;
         end
         qrs_pkg::KIND_DISTINCT: begin
            v1 = (nb + s) / den;
            v2 = (nb - s) / den;
         end
         default: begin
            v1 = nb / den;
            v2 = s / den;
         end
      endcase
      r.x1 = clip32(v1, r.sat);
      r.x2 = clip32(v2, r.sat);
      return r;
   endfunction

   assign pending_roots = root_queue.size();

   always @(posedge clock) begin
      roots_type e;
      if (reset) begin
         fail_count <= 0;
         root_queue.delete();
      end else begin
         if (start && !busy)
            root_queue.push_back(solve_roots(req_coef_a, req_coef_b, req_coef_c));
         if (rsp_strobe) begin
            if (root_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result beat");
            end else begin
               e = root_queue.pop_front();
               if (rsp_root_kind !== e.kind || rsp_first_value !== e.x1
                   || rsp_second_value !== e.x2 || rsp_saturated !== e.sat) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: exp %0d %h %h %b got %0d %h %h %b",
                        e.kind, e.x1, e.x2, e.sat, rsp_root_kind,
                        rsp_first_value, rsp_second_value, rsp_saturated);
               end
            end
         end
      end
   end
endmodule

[tb/sv/quadratic_root_solver_tb.sv]
// quadratic_root_solver_tb: clock, reset, coefficient stimulus and verdict.
// Depends on qrs_pkg, quadratic_root_solver and quadratic_root_solver_chk.
module quadratic_root_solver_tb;

   localparam int WatchLimit = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic signed [15:0]    coef_a = 0;
   logic signed [15:0]    coef_b = 0;
   logic signed [15:0]    coef_c = 0;
   logic                  rsp_strobe;
   logic [1:0]            rsp_root_kind;
   logic signed [31:0]    rsp_first_value;
   logic signed [31:0]    rsp_second_value;
   logic                  rsp_saturated;
   int                    fail_count;
   int                    pending_roots;
   int                    quiet_cycles = 0;
   int                    idle_pct = 0;

   always #5 clock = ~clock;

   quadratic_root_solver uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_a(coef_a), .req_coef_b(coef_b), .req_coef_c(coef_c),
      .rsp_strobe(rsp_strobe), .rsp_root_kind(rsp_root_kind),
      .rsp_first_value(rsp_first_value), .rsp_second_value(rsp_second_value),
      .rsp_saturated(rsp_saturated)
   );

   quadratic_root_solver_chk chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_a(coef_a), .req_coef_b(coef_b), .req_coef_c(coef_c),
      .rsp_strobe(rsp_strobe), .rsp_root_kind(rsp_root_kind),
      .rsp_first_value(rsp_first_value), .rsp_second_value(rsp_second_value),
      .rsp_saturated(rsp_saturated), .fail_count(fail_count),
      .pending_roots(pending_roots)
   );

   // watchdog: cycles with no beat on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one beat; random idle cycles ahead of it
   task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start  <= 1'b1;
      coef_a <= a;
      coef_b <= b;
      coef_c <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(5))
         0: return 16'($urandom_range(7)) - 16'd3;
         1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         2: return 16'($signed(16'($urandom_range(2047))) - 1024);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] a;
      logic [15:0] b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, degenerate, equal and complex roots, negative a
      send_coefs(16'h0000, 16'h1234, 16'h0100);
      send_coefs(16'h0000, 16'h0000, 16'h0000);
      send_coefs(16'h0100, 16'h0000, 16'hff00);   // x^2 - 1
      send_coefs(16'h0100, 16'hfe00, 16'h0100);   // (x-1)^2
      send_coefs(16'h0100, 16'h0000, 16'h0100);   // x^2 + 1
      send_coefs(16'hff00, 16'h0000, 16'h0100);   // -x^2 + 1
      send_coefs(16'hff00, 16'h0000, 16'hff00);   // complex, negative a
      send_coefs(16'h0001, 16'h7fff, 16'h0000);   // large root just inside the Q16.16 range
      send_coefs(16'h0001, 16'h8000, 16'h8000);
      send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
      send_coefs(16'h8000, 16'h8000, 16'h8000);
      send_coefs(16'h8000, 16'h7fff, 16'h7fff);
      send_coefs(16'h7fff, 16'h8000, 16'h8000);
      send_coefs(16'hffff, 16'hffff, 16'hffff);
      send_coefs(16'h0001, 16'h0002, 16'h0001);   // equal, tiny
      send_coefs(16'h4000, 16'h8000, 16'h4000);   // b*b == 4ac at extremes
      send_coefs(16'h5555, 16'haaaa, 16'h5555);
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 0) ? 0 : (ph == 1) ? 88 : (ph == 2) ? 33 : 0;
         for (int i = 0; i < 135; i++) begin
            a = rand_coef();
            b = rand_coef();
            if ($urandom_range(3) == 0) begin
               // equal roots: c = b*b / 4a with b a multiple of 32 and a = 1.0
               a = 16'h0100;
               b = 16'(($urandom_range(255) - 128) * 32);
               send_coefs(a, b, 16'(($signed(b) * $signed(b)) / 1024));
            end else
               send_coefs(a, b, rand_coef());
         end
         // drain before next phase
         start <= 1'b0;
         @(posedge clock);
         while (pending_roots != 0) @(posedge clock);
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_roots != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_roots == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

[files.f]
src/qrs_pkg.sv
src/qrs_front.sv
src/qrs_fifo.sv
src/qrs_sqrt.sv
src/qrs_div.sv
src/qrs_back.sv
src/quadratic_root_solver.sv
tb/sv/quadratic_root_solver_chk.sv
tb/sv/quadratic_root_solver_tb.sv
